// ===== hw/rtl/cim_pkg.sv =====
// ============================================================================
// cim_pkg
// Shared types, codes and helpers of the CIDR include/exclude matcher.
// ============================================================================
package cim_pkg;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 64;

    // request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // insert status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EXCL_ANY = 2'd3;

    // bit positions inside an entry kind
    localparam int KIND_EXCL = 0;
    localparam int KIND_ANY  = 1;
    localparam int KIND_V6   = 2;

    // one request as it arrives
    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix_len;
        logic        is_ipv6;
        logic        negated;
        logic        any_flag;
    } req_t;

    // one result
    typedef struct packed {
        logic       matched;
        logic [1:0] status;
    } res_t;

    // one table word
    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  prefix;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic wipe;
        logic rd_en;
        logic eval;
        logic commit;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic skip;
        logic is_clear;
    } stat_t;

    // network mask of a prefix; ipv4 masks live in the low 32 bits
    function automatic logic [127:0] prefix_mask(input logic v6, input logic [7:0] pfx);
        logic [31:0]  m4;
        logic [127:0] m6;
        m4 = ~(32'hFFFF_FFFF >> pfx);
        m6 = ~({128{1'b1}} >> pfx);
        if (v6)
        begin
            return m6;
        end
        return {96'd0, m4};
    endfunction

endpackage

// ===== hw/rtl/cim_ram.sv =====
// ============================================================================
// cim_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module cim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/cim_dp.sv =====
// ============================================================================
// cim_dp
// Datapath: request register, entry table, per-entry match and duplicate
// evaluation, free slot search, list flags and result register.
// ============================================================================
module cim_dp #(
    parameter int TABLE_ENTRIES = cim_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cim_pkg::req_t        request,
    output cim_pkg::res_t        result,
    output logic                 done,
    input  cim_pkg::cmd_t        cmd,
    input  logic [IDX_W-1:0]     idx,
    input  logic [IDX_W-1:0]     eval_idx,
    output cim_pkg::stat_t       stat
);

    cim_pkg::req_t   req_reg;
    cim_pkg::entry_t e;
    cim_pkg::entry_t wdata;
    cim_pkg::entry_t new_entry;
    logic [cim_pkg::ENTRY_W-1:0] rdata;
    logic                        we;
    logic [IDX_W-1:0]            waddr;

    // accumulators over one walk
    logic excl_hit_reg, excl_hit_next;
    logic inc_hit_reg, inc_hit_next;
    logic dup_reg, dup_next;
    logic free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // list flags and result
    logic any_held_reg, any_held_next;
    logic inc_nonempty_reg, inc_nonempty_next;
    logic done_reg, done_next;
    cim_pkg::res_t result_reg, result_next;

    // prepared insert entry
    logic [7:0]   pfx_sat;
    logic [127:0] ins_mask;
    logic [127:0] ins_addr;
    logic [2:0]   ins_kind;
    logic [7:0]   ins_pfx;
    logic         ins_zero;
    logic         is_insert;
    logic         skip;
    logic [1:0]   skip_status;
    logic         ins_ok;

    // lookup evaluation
    logic [127:0] lu_addr;
    logic [127:0] ent_mask;
    logic         ent_match;
    logic         fam;
    logic         ent_excl;
    logic         ent_zero;
    logic         inval;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    // saturate, mask and shape the entry to insert
    always_comb
    begin
        if (req_reg.is_ipv6)
        begin
            pfx_sat = (req_reg.prefix_len > 8'd128) ? 8'd128 : req_reg.prefix_len;
        end
        else
        begin
            pfx_sat = (req_reg.prefix_len > 8'd32) ? 8'd32 : req_reg.prefix_len;
        end
        ins_mask = cim_pkg::prefix_mask(req_reg.is_ipv6, pfx_sat);
        ins_addr = req_reg.any_flag ? 128'd0
                 : ({req_reg.addr_high, req_reg.addr_low} & ins_mask);
        ins_pfx  = req_reg.any_flag ? 8'd0 : pfx_sat;
        ins_kind[cim_pkg::KIND_EXCL] = req_reg.negated;
        ins_kind[cim_pkg::KIND_ANY]  = req_reg.any_flag;
        ins_kind[cim_pkg::KIND_V6]   = req_reg.is_ipv6 & ~req_reg.any_flag;
        ins_zero = (ins_addr == 128'd0);
    end

    // requests settled without a walk
    always_comb
    begin
        is_insert   = (req_reg.req_type == cim_pkg::REQ_INSERT);
        skip        = 1'b0;
        skip_status = cim_pkg::ST_OK;
        priority if (req_reg.req_type == cim_pkg::REQ_UNUSED)
        begin
            skip = 1'b1;
        end
        else if (is_insert && req_reg.negated && (req_reg.any_flag || ins_zero))
        begin
            skip        = 1'b1;
            skip_status = cim_pkg::ST_EXCL_ANY;
        end
        else if (is_insert && !req_reg.negated && any_held_reg)
        begin
            skip        = 1'b1;
            skip_status = cim_pkg::ST_IGNORED;
        end
        else
        begin
            skip = 1'b0;
        end
    end

    assign stat.skip     = skip;
    assign stat.is_clear = (req_reg.req_type == cim_pkg::REQ_CLEAR);

    // entry table
    cim_ram #(
        .WIDTH (cim_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (idx),
        .rdata (rdata)
    );

    assign e = rdata;

    // evaluation of the entry just read
    always_comb
    begin
        lu_addr   = req_reg.is_ipv6 ? {req_reg.addr_high, req_reg.addr_low}
                                    : {96'd0, req_reg.addr_low[31:0]};
        ent_mask  = cim_pkg::prefix_mask(e.kind[cim_pkg::KIND_V6], e.prefix);
        ent_match = ((lu_addr & ent_mask) == {e.addr_high, e.addr_low});
        fam       = (e.kind[cim_pkg::KIND_V6] == req_reg.is_ipv6);
        ent_excl  = e.kind[cim_pkg::KIND_EXCL];
        ent_zero  = (e.addr_high == 64'd0) && (e.addr_low == 64'd0);
        inval     = is_insert && req_reg.any_flag && e.valid && !ent_excl;
    end

    // accumulate over the walk
    always_comb
    begin
        excl_hit_next   = excl_hit_reg;
        inc_hit_next    = inc_hit_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (cmd.load)
        begin
            excl_hit_next   = 1'b0;
            inc_hit_next    = 1'b0;
            dup_next        = 1'b0;
            free_found_next = 1'b0;
        end
        else if (cmd.eval)
        begin
            if (e.valid && ent_excl && fam && ent_match)
            begin
                excl_hit_next = 1'b1;
            end
            if (e.valid && !ent_excl
                && (e.kind[cim_pkg::KIND_ANY] || ent_zero || (fam && ent_match)))
            begin
                inc_hit_next = 1'b1;
            end
            if (e.valid && (e.kind == ins_kind) && (e.prefix == ins_pfx)
                && ({e.addr_high, e.addr_low} == ins_addr))
            begin
                dup_next = 1'b1;
            end
            if (!free_found_reg && (!e.valid || inval))
            begin
                free_found_next = 1'b1;
                free_idx_next   = eval_idx;
            end
        end
    end

    // new table word
    always_comb
    begin
        new_entry.valid     = 1'b1;
        new_entry.kind      = ins_kind;
        new_entry.prefix    = ins_pfx;
        new_entry.addr_high = ins_addr[127:64];
        new_entry.addr_low  = ins_addr[63:0];
        ins_ok = is_insert && !skip && !dup_reg && free_found_reg;
    end

    // table write port
    always_comb
    begin
        we    = 1'b0;
        waddr = idx;
        wdata = '0;
        priority if (cmd.wipe)
        begin
            we = 1'b1;
        end
        else if (cmd.eval && inval)
        begin
            we          = 1'b1;
            waddr       = eval_idx;
            wdata       = e;
            wdata.valid = 1'b0;
        end
        else if (cmd.commit && ins_ok)
        begin
            we    = 1'b1;
            waddr = free_idx_reg;
            wdata = new_entry;
        end
        else
        begin
            we = 1'b0;
        end
    end

    // result and list flags at the end of a request
    always_comb
    begin
        any_held_next     = any_held_reg;
        inc_nonempty_next = inc_nonempty_reg;
        done_next         = cmd.commit;
        result_next       = '0;
        if (cmd.commit)
        begin
            unique case (req_reg.req_type)
                cim_pkg::REQ_CLEAR:
                begin
                    any_held_next     = 1'b0;
                    inc_nonempty_next = 1'b0;
                end
                cim_pkg::REQ_INSERT:
                begin
                    if (skip)
                    begin
                        result_next.status = skip_status;
                    end
                    else
                    begin
                        // an any insert has already emptied the include list
                        if (req_reg.any_flag)
                        begin
                            inc_nonempty_next = 1'b0;
                        end
                        priority if (dup_reg)
                        begin
                            result_next.status = cim_pkg::ST_IGNORED;
                        end
                        else if (!free_found_reg)
                        begin
                            result_next.status = cim_pkg::ST_FULL;
                        end
                        else
                        begin
                            result_next.status = cim_pkg::ST_OK;
                            if (!req_reg.negated)
                            begin
                                inc_nonempty_next = 1'b1;
                            end
                            if (req_reg.any_flag)
                            begin
                                any_held_next = 1'b1;
                            end
                        end
                    end
                end
                cim_pkg::REQ_LOOKUP:
                begin
                    result_next.matched = !excl_hit_reg && (!inc_nonempty_reg || inc_hit_reg);
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            excl_hit_reg     <= 1'b0;
            inc_hit_reg      <= 1'b0;
            dup_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            any_held_reg     <= 1'b0;
            inc_nonempty_reg <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            excl_hit_reg     <= excl_hit_next;
            inc_hit_reg      <= inc_hit_next;
            dup_reg          <= dup_next;
            free_found_reg   <= free_found_next;
            any_held_reg     <= any_held_next;
            inc_nonempty_reg <= inc_nonempty_next;
            done_reg         <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a result strobe always follows a commit
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.commit))
        else $error("result strobe without commit");

    // only inserts report a non-ok status
    a_status_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status != cim_pkg::ST_OK)
            |-> req_reg.req_type == cim_pkg::REQ_INSERT)
        else $error("status on a non-insert request");

    // only lookups report a match
    a_match_lookup_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.matched) |-> req_reg.req_type == cim_pkg::REQ_LOOKUP)
        else $error("match on a non-lookup request");

    // an any entry on the include list keeps that list non-empty
    a_any_implies_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        any_held_reg |-> inc_nonempty_reg)
        else $error("any held with empty include list");

endmodule

// ===== hw/rtl/cim_ctrl.sv =====
// ============================================================================
// cim_ctrl
// Controller: reset clearing pass, request decode, table walk sequencing
// and commit of each request.
// ============================================================================
module cim_ctrl #(
    parameter int TABLE_ENTRIES = cim_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output cim_pkg::cmd_t        cmd,
    output logic [IDX_W-1:0]     idx,
    output logic [IDX_W-1:0]     eval_idx,
    input  cim_pkg::stat_t       stat
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECIDE,
        S_CLEAR,
        S_WALK,
        S_DRAIN,
        S_COMMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             eval_reg, eval_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        eval_next     = (state_reg == S_WALK);
        eval_idx_next = idx_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.wipe = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (stat.skip)
                begin
                    state_next = S_COMMIT;
                end
                else if (stat.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_CLEAR:
            begin
                cmd.wipe = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_COMMIT;
                end
            end
            S_WALK:
            begin
                cmd.rd_en = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
        endcase
        cmd.eval = eval_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            idx_reg      <= '0;
            eval_reg     <= 1'b0;
            eval_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            eval_reg     <= eval_next;
            eval_idx_reg <= eval_idx_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign idx      = idx_reg;
    assign eval_idx = eval_idx_reg;

    // an accepted request always goes to decode
    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> state_reg == S_DECIDE)
        else $error("accepted request not decoded");

    // evaluation only ever follows a table read
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> $past(cmd.rd_en))
        else $error("evaluation without a read");

endmodule

// ===== hw/rtl/cidr_include_exclude_matcher.sv =====
// ============================================================================
// cidr_include_exclude_matcher
// Table of include/exclude CIDR entries with clear, insert and lookup
// requests; lookups and inserts walk the table one entry per cycle.
// ============================================================================
//
//  channel   handshake           payload              direction
//  request   start, busy         request (req_t)      in
//  result    done (strobe)       result (res_t)       out
//
//  A request is taken when start is high and busy is low.
//  Lookup and insert run from acceptance through decode, the table walk through
//  the single read port of the entry RAM, a drain state and commit to the done
//  strobe; clear wipes every entry instead of walking, and refused inserts and
//  unknown requests go from decode straight to commit. After reset a clearing
//  pass wipes every entry with busy high. The strobe lasts one cycle; the
//  receiver cannot stall, and a new request may be taken in the strobe cycle.
//
module cidr_include_exclude_matcher #(
    parameter int TABLE_ENTRIES = cim_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cim_pkg::req_t request,
    output logic          done,
    output cim_pkg::res_t result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    cim_pkg::cmd_t    cmd;
    cim_pkg::stat_t   stat;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] eval_idx;

    // controller
    cim_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .idx      (idx),
        .eval_idx (eval_idx),
        .stat     (stat)
    );

    // datapath
    cim_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .result   (result),
        .done     (done),
        .cmd      (cmd),
        .idx      (idx),
        .eval_idx (eval_idx),
        .stat     (stat)
    );

endmodule
